// ----- hdl/dmac_pkg.sv -----
// Shared widths, select codes and control types for the multiply-accumulate unit.
`default_nettype none
package dmac_pkg;

	localparam int BUS_W  = 16;
	localparam int OP_W   = 17;
	localparam int PROD_W = 34;
	localparam int ACC_W  = 40;
	localparam int RND_W  = 16;
	localparam int AHI_LO = 16;
	localparam int AHI_HI = 32;

	// X operand sources
	localparam logic [1:0] XS_T   = 2'd0;
	localparam logic [1:0] XS_DB  = 2'd1;
	localparam logic [1:0] XS_AHI = 2'd2;
	localparam logic [1:0] XS_DBU = 2'd3;

	// Y operand sources; the remaining codes give a zero operand
	localparam logic [2:0] YS_P   = 3'd0;
	localparam logic [2:0] YS_DB  = 3'd1;
	localparam logic [2:0] YS_AHI = 3'd2;
	localparam logic [2:0] YS_CB  = 3'd3;
	localparam logic [2:0] YS_DBU = 3'd4;

	// Accumulate modes; the remaining codes act as product only
	localparam logic [2:0] AM_PROD  = 3'd0;
	localparam logic [2:0] AM_ADD_A = 3'd1;
	localparam logic [2:0] AM_ADD_B = 3'd2;
	localparam logic [2:0] AM_SUB_A = 3'd3;
	localparam logic [2:0] AM_SUB_B = 3'd4;

	// Store mode bits
	localparam int SM_DEST_BIT  = 0;
	localparam int SM_ROUND_BIT = 1;

	typedef logic signed [OP_W-1:0] operand_t;
	typedef logic [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [2:0] acc_mode;
		logic       to_b;
		logic       round;
	} mac_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/dmac_opsel.sv -----
// Operand selection: builds the 17-bit signed X and Y multiplier inputs.
`default_nettype none
module dmac_opsel (
	input  logic [1:0]                    x_select,
	input  logic [2:0]                    y_select,
	input  logic [dmac_pkg::BUS_W-1:0]    t_word,
	input  logic [dmac_pkg::BUS_W-1:0]    db_word,
	input  logic [dmac_pkg::BUS_W-1:0]    cb_word,
	input  logic [dmac_pkg::BUS_W-1:0]    p_word,
	input  logic [dmac_pkg::OP_W-1:0]     a_high,
	output dmac_pkg::operand_t            x_op,
	output dmac_pkg::operand_t            y_op
);
	import dmac_pkg::*;

	logic [OP_W-1:0] t_sx;
	logic [OP_W-1:0] db_sx;
	logic [OP_W-1:0] db_zx;
	logic [OP_W-1:0] cb_sx;
	logic [OP_W-1:0] p_sx;

	assign t_sx  = {t_word[BUS_W-1], t_word};
	assign db_sx = {db_word[BUS_W-1], db_word};
	assign db_zx = {1'b0, db_word};
	assign cb_sx = {cb_word[BUS_W-1], cb_word};
	assign p_sx  = {p_word[BUS_W-1], p_word};

	always_comb begin
		case (x_select)
			XS_T:    x_op = operand_t'(t_sx);
			XS_DB:   x_op = operand_t'(db_sx);
			XS_AHI:  x_op = operand_t'(a_high);
			default: x_op = operand_t'(db_zx);
		endcase
	end

	always_comb begin
		case (y_select)
			YS_P:    y_op = operand_t'(p_sx);
			YS_DB:   y_op = operand_t'(db_sx);
			YS_AHI:  y_op = operand_t'(a_high);
			YS_CB:   y_op = operand_t'(cb_sx);
			YS_DBU:  y_op = operand_t'(db_zx);
			default: y_op = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- hdl/dmac_core.sv -----
// Multiply, accumulate and round datapath with the A and B accumulators.
`default_nettype none
module dmac_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  dmac_pkg::mac_ctrl_t           ctrl,
	input  dmac_pkg::operand_t            x_op,
	input  dmac_pkg::operand_t            y_op,
	output logic [dmac_pkg::OP_W-1:0]     a_high,
	output logic [dmac_pkg::ACC_W-1:0]    result,
	output logic                          wrote_b
);
	import dmac_pkg::*;

	acc_t                    acc_a_q;
	acc_t                    acc_b_q;
	acc_t                    res_q;
	logic                    wrote_b_q;
	logic signed [PROD_W-1:0] prod;
	acc_t                    prod_ext;
	acc_t                    base;
	acc_t                    addend;
	acc_t                    rnd;
	logic                    sub;
	acc_t                    sum;
	acc_t                    res_next;

	assign a_high = acc_a_q[AHI_HI:AHI_LO];

	assign prod     = PROD_W'(x_op) * PROD_W'(y_op);
	assign prod_ext = acc_t'({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});

	always_comb begin
		base = '0;
		sub  = 1'b0;
		case (ctrl.acc_mode)
			AM_ADD_A: base = acc_a_q;
			AM_ADD_B: base = acc_b_q;
			AM_SUB_A: begin
				base = acc_a_q;
				sub  = 1'b1;
			end
			AM_SUB_B: begin
				base = acc_b_q;
				sub  = 1'b1;
			end
			default: base = '0;
		endcase
	end

	// subtract as base + ~prod + 1; fold the rounding constant into the same add
	assign addend = sub ? ~prod_ext : prod_ext;
	assign rnd    = ctrl.round ? (acc_t'(1) << (RND_W - 1)) : '0;
	assign sum    = base + addend + rnd + acc_t'(sub);

	always_comb begin
		res_next = sum;
		if (ctrl.round) begin
			res_next[RND_W-1:0] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_a_q <= '0;
			acc_b_q <= '0;
		end else if (advance) begin
			if (ctrl.to_b) begin
				acc_b_q <= res_next;
			end else begin
				acc_a_q <= res_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q     <= res_next;
			wrote_b_q <= ctrl.to_b;
		end
	end

	assign result  = res_q;
	assign wrote_b = wrote_b_q;

endmodule
`default_nettype wire

// ----- hdl/dsp_multiply_accumulate_unit.sv -----
// Top level: input register, operand select, MAC datapath and result register.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_ready   x_select y_select acc_mode store_mode
//                                             t_word db_word cb_word p_word
//   out      source     out_valid / out_ready acc_result wrote_b
//
// One word per cycle sustained while the output is taken; an accepted word goes to the
// input register, then is multiply-accumulated into the result register.
// Accumulators update as a word leaves the input register, so the next word
// always sees them current. Reset clears both accumulators and the valid flags.
// A stalled output holds its word; the input register still takes one more.
`default_nettype none
module dsp_multiply_accumulate_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    x_select,
	input  logic [2:0]                    y_select,
	input  logic [2:0]                    acc_mode,
	input  logic [1:0]                    store_mode,
	input  logic [dmac_pkg::BUS_W-1:0]    t_word,
	input  logic [dmac_pkg::BUS_W-1:0]    db_word,
	input  logic [dmac_pkg::BUS_W-1:0]    cb_word,
	input  logic [dmac_pkg::BUS_W-1:0]    p_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [dmac_pkg::ACC_W-1:0] acc_result,
	output logic                          wrote_b
);
	import dmac_pkg::*;

	logic               vld_s1;
	logic [1:0]         xs_s1;
	logic [2:0]         ys_s1;
	logic [2:0]         am_s1;
	logic [1:0]         sm_s1;
	logic [BUS_W-1:0]   t_s1;
	logic [BUS_W-1:0]   db_s1;
	logic [BUS_W-1:0]   cb_s1;
	logic [BUS_W-1:0]   p_s1;
	logic               out_valid_q;
	logic               advance;
	logic               accept;
	mac_ctrl_t          ctrl;
	operand_t           x_op;
	operand_t           y_op;
	logic [OP_W-1:0]    a_high;
	logic [ACC_W-1:0]   result;

	assign advance  = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready = !vld_s1 || advance;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xs_s1 <= x_select;
			ys_s1 <= y_select;
			am_s1 <= acc_mode;
			sm_s1 <= store_mode;
			t_s1  <= t_word;
			db_s1 <= db_word;
			cb_s1 <= cb_word;
			p_s1  <= p_word;
		end
	end

	assign ctrl.acc_mode = am_s1;
	assign ctrl.to_b     = sm_s1[SM_DEST_BIT];
	assign ctrl.round    = sm_s1[SM_ROUND_BIT];

	dmac_opsel u_opsel (
		.x_select (xs_s1),
		.y_select (ys_s1),
		.t_word   (t_s1),
		.db_word  (db_s1),
		.cb_word  (cb_s1),
		.p_word   (p_s1),
		.a_high   (a_high),
		.x_op     (x_op),
		.y_op     (y_op)
	);

	dmac_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ctrl    (ctrl),
		.x_op    (x_op),
		.y_op    (y_op),
		.a_high  (a_high),
		.result  (result),
		.wrote_b (wrote_b)
	);

	assign out_valid  = out_valid_q;
	assign acc_result = $signed(result);

endmodule
`default_nettype wire

// ----- hdl/dmac_checker.sv -----
// Port-level checks for the multiply-accumulate unit, bound to the top level.
`default_nettype none
module dmac_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         y_select,
	input  logic [2:0]         acc_mode,
	input  logic [1:0]         store_mode,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [39:0] acc_result,
	input  logic               wrote_b
);
	import dmac_pkg::*;

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(acc_result) && $stable(wrote_b))
		else $error("result word changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// rounded word shows with clear low half and the right destination
	a_round: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && store_mode[SM_ROUND_BIT] ##1 out_ready
		|=> out_valid && acc_result[15:0] == 16'd0
		&& wrote_b == $past(store_mode[SM_DEST_BIT], 2))
		else $error("rounded result wrong");

	// Y codes past the unsigned data bus select a zero operand
	a_zero_y: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && acc_mode == AM_PROD && !store_mode[SM_ROUND_BIT]
		&& y_select > YS_DBU ##1 out_ready
		|=> out_valid && acc_result == 40'sd0)
		else $error("zero Y operand gave nonzero product");

endmodule

bind dsp_multiply_accumulate_unit dmac_checker u_dmac_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.y_select   (y_select),
	.acc_mode   (acc_mode),
	.store_mode (store_mode),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.acc_result (acc_result),
	.wrote_b    (wrote_b)
);
`default_nettype wire

// ----- bench/tb_dsp_multiply_accumulate_unit.sv -----
// Self-checking testbench for the dual-accumulator multiply-accumulate unit.
`timescale 1ns / 100ps

module tb_dsp_multiply_accumulate_unit;
	import dmac_pkg::*;

	// codes with no name in the package: zero Y operand, product-only mode
	localparam logic [2:0] YS_ZERO5 = 3'd5;
	localparam logic [2:0] YS_ZERO6 = 3'd6;
	localparam logic [2:0] YS_ZERO7 = 3'd7;
	localparam logic [2:0] AM_SPARE5 = 3'd5;
	localparam logic [2:0] AM_SPARE6 = 3'd6;
	localparam logic [2:0] AM_SPARE7 = 3'd7;
	localparam logic [1:0] SM_A     = 2'd0;
	localparam logic [1:0] SM_B     = 2'd1;
	localparam logic [1:0] SM_A_RND = 2'd2;
	localparam logic [1:0] SM_B_RND = 2'd3;

	localparam int RANDOM_WORDS = 690;
	localparam int RAMP_WORDS   = 140;
	localparam int STALL_AT     = 650;
	localparam int STALL_CYCLES = 60;

	typedef struct {
		logic [1:0]       xs;
		logic [2:0]       ys;
		logic [2:0]       am;
		logic [1:0]       sm;
		logic [BUS_W-1:0] t;
		logic [BUS_W-1:0] db;
		logic [BUS_W-1:0] cb;
		logic [BUS_W-1:0] p;
		bit               drain;
	} mac_word_t;

	typedef struct {
		acc_t value;
		logic to_b;
	} acc_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] x_select = '0;
	logic [2:0] y_select = '0;
	logic [2:0] acc_mode = '0;
	logic [1:0] store_mode = '0;
	logic [BUS_W-1:0] t_word = '0;
	logic [BUS_W-1:0] db_word = '0;
	logic [BUS_W-1:0] cb_word = '0;
	logic [BUS_W-1:0] p_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [ACC_W-1:0] acc_result;
	logic wrote_b;

	mac_word_t  pending_words[$];
	acc_write_t acc_expected[$];
	mac_word_t  bus_word;
	acc_t       shadow_a = '0;
	acc_t       shadow_b = '0;
	int         n_accepted = 0;
	int         n_mismatches = 0;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         stall_left = 0;
	bit         stall_done = 1'b0;

	dsp_multiply_accumulate_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.x_select   (x_select),
		.y_select   (y_select),
		.acc_mode   (acc_mode),
		.store_mode (store_mode),
		.t_word     (t_word),
		.db_word    (db_word),
		.cb_word    (cb_word),
		.p_word     (p_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.acc_result (acc_result),
		.wrote_b    (wrote_b)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// MAC step on the shadow accumulators; A is read before it is written
	function automatic acc_write_t mac_predict(input mac_word_t w);
		operand_t x, y, a_hi;
		logic signed [PROD_W-1:0] prod;
		acc_t prod_ext, sum;
		acc_write_t r;
		a_hi = $signed(shadow_a[AHI_HI:AHI_LO]);
		case (w.xs)
			XS_T:    x = {w.t[BUS_W-1], w.t};
			XS_DB:   x = {w.db[BUS_W-1], w.db};
			XS_AHI:  x = a_hi;
			default: x = {1'b0, w.db};
		endcase
		case (w.ys)
			YS_P:    y = {w.p[BUS_W-1], w.p};
			YS_DB:   y = {w.db[BUS_W-1], w.db};
			YS_AHI:  y = a_hi;
			YS_CB:   y = {w.cb[BUS_W-1], w.cb};
			YS_DBU:  y = {1'b0, w.db};
			default: y = '0;
		endcase
		prod = PROD_W'(x) * PROD_W'(y);
		prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		case (w.am)
			AM_ADD_A: sum = shadow_a + prod_ext;
			AM_ADD_B: sum = shadow_b + prod_ext;
			AM_SUB_A: sum = shadow_a - prod_ext;
			AM_SUB_B: sum = shadow_b - prod_ext;
			default:  sum = prod_ext;
		endcase
		if (w.sm[SM_ROUND_BIT])
			sum = (sum + (acc_t'(1) << (RND_W-1))) & ~((acc_t'(1) << RND_W) - 1);
		r.to_b = w.sm[SM_DEST_BIT];
		r.value = sum;
		if (r.to_b)
			shadow_b = sum;
		else
			shadow_a = sum;
		return r;
	endfunction

	task automatic flag_mismatch(input string what);
		if (n_mismatches < 10)
			$display("MISMATCH @%0t: %s", $realtime, what);
		n_mismatches++;
	endtask

	task automatic queue_word(input logic [1:0] xs, input logic [2:0] ys, input logic [2:0] am,
			input logic [1:0] sm, input logic [BUS_W-1:0] t, input logic [BUS_W-1:0] db,
			input logic [BUS_W-1:0] cb, input logic [BUS_W-1:0] p, input bit drain);
		mac_word_t w;
		w.xs = xs; w.ys = ys; w.am = am; w.sm = sm;
		w.t = t; w.db = db; w.cb = cb; w.p = p; w.drain = drain;
		pending_words.push_back(w);
	endtask

	// lean toward the corners of the 16-bit range
	function automatic logic [BUS_W-1:0] pick_bus_word();
		case ($urandom_range(7))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'hFFFF;
			3:       return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [2:0] pick_y_select();
		if ($urandom_range(9) == 0)
			return 3'($urandom_range(5, 7));
		return 3'($urandom_range(4));
	endfunction

	function automatic logic [2:0] pick_acc_mode();
		if ($urandom_range(9) == 0)
			return 3'($urandom_range(5, 7));
		return 3'($urandom_range(4));
	endfunction

	always_comb begin
		if (n_accepted < 320) begin
			send_idle_pct = 8;
			recv_idle_pct = 71;
		end else if (n_accepted < 600) begin
			send_idle_pct = 71;
			recv_idle_pct = 8;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	end

	// driver: predict on acceptance, then offer the next word when the slot frees
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				acc_expected.push_back(mac_predict(bus_word));
				n_accepted <= n_accepted + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct &&
						!(pending_words[0].drain && acc_expected.size() != 0)) begin
					bus_word = pending_words.pop_front();
					in_valid   <= 1'b1;
					x_select   <= bus_word.xs;
					y_select   <= bus_word.ys;
					acc_mode   <= bus_word.am;
					store_mode <= bus_word.sm;
					t_word     <= bus_word.t;
					db_word    <= bus_word.db;
					cb_word    <= bus_word.cb;
					p_word     <= bus_word.p;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once, while the sender keeps offering
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (!stall_done && n_accepted >= STALL_AT) begin
			stall_left <= STALL_CYCLES;
			stall_done <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		out_ready <= arst_n && stall_left == 0 && $urandom_range(99) >= recv_idle_pct;
	end

	// monitor: compare each result word with the oldest expectation
	always @(posedge clk) begin
		acc_write_t want;
		if (arst_n && out_valid && out_ready) begin
			if (acc_expected.size() == 0) begin
				flag_mismatch($sformatf("unexpected word acc_result=%h wrote_b=%b",
					acc_result, wrote_b));
			end else begin
				want = acc_expected.pop_front();
				if (acc_result !== want.value)
					flag_mismatch($sformatf("acc_result expected %h got %h",
						want.value, acc_result));
				if (wrote_b !== want.to_b)
					flag_mismatch($sformatf("wrote_b expected %b got %b",
						want.to_b, wrote_b));
			end
		end
	end

	initial begin
		int guard;
		// corners, every select and mode, unused codes, rounding edges
		queue_word(XS_T, YS_P, AM_PROD, SM_A, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 0);
		queue_word(XS_DB, YS_DB, AM_ADD_A, SM_A, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0);
		queue_word(XS_AHI, YS_AHI, AM_ADD_B, SM_B, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_word(XS_DBU, YS_DBU, AM_SUB_A, SM_A_RND, 16'h0000, 16'hFFFF, 16'h0000,
			16'h0000, 0);
		queue_word(XS_T, YS_CB, AM_SUB_B, SM_B_RND, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 0);
		queue_word(XS_AHI, YS_DBU, AM_ADD_A, SM_A, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 0);
		queue_word(XS_AHI, YS_AHI, AM_SUB_A, SM_B, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_word(XS_DB, YS_ZERO5, AM_ADD_A, SM_A, 16'h0000, 16'h1234, 16'h0000, 16'h0000, 0);
		queue_word(XS_T, YS_ZERO6, AM_PROD, SM_B, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 0);
		queue_word(XS_DBU, YS_ZERO7, AM_SUB_B, SM_B_RND, 16'h0000, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 0);
		queue_word(XS_T, YS_P, AM_SPARE5, SM_A, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 0);
		queue_word(XS_DB, YS_CB, AM_SPARE6, SM_B, 16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 0);
		queue_word(XS_DBU, YS_DB, AM_SPARE7, SM_A_RND, 16'h0000, 16'hFFFF, 16'h0000,
			16'h0000, 0);
		queue_word(XS_DBU, YS_ZERO7, AM_SPARE7, SM_B_RND, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 0);
		queue_word(XS_T, YS_P, AM_PROD, SM_A, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		// -2^15 rounds up through zero; 2^15-1 rounds down; +2^15 rounds up
		queue_word(XS_T, YS_P, AM_PROD, SM_A_RND, 16'h0001, 16'h0000, 16'h0000, 16'h8000, 0);
		queue_word(XS_T, YS_P, AM_PROD, SM_B_RND, 16'h0001, 16'h0000, 16'h0000, 16'h7FFF, 0);
		queue_word(XS_DBU, YS_P, AM_PROD, SM_A_RND, 16'h0000, 16'h8000, 16'h0000, 16'h0001, 0);
		queue_word(XS_DBU, YS_DBU, AM_SUB_B, SM_B, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 0);
		queue_word(XS_AHI, YS_P, AM_ADD_A, SM_A_RND, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 0);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 250) begin
				// zero B, then pile up near-maximal products until B wraps
				queue_word(XS_DB, YS_ZERO5, AM_PROD, SM_B, pick_bus_word(), pick_bus_word(),
					pick_bus_word(), pick_bus_word(), 0);
				for (int k = 0; k < RAMP_WORDS; k++)
					queue_word(XS_DBU, YS_DBU, AM_ADD_B, $urandom_range(1) ? SM_B : SM_B_RND,
						pick_bus_word(), 16'($urandom_range(16'hFC00, 16'hFFFF)),
						pick_bus_word(), pick_bus_word(), 0);
			end
			queue_word(2'($urandom_range(3)), pick_y_select(), pick_acc_mode(),
				2'($urandom_range(3)), pick_bus_word(), pick_bus_word(), pick_bus_word(),
				pick_bus_word(), i == 200 || i == 560);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid)
			@(posedge clk);
		for (guard = 0; guard < 5000 && acc_expected.size() != 0; guard++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (acc_expected.size() != 0)
			flag_mismatch($sformatf("%0d expected words never arrived", acc_expected.size()));
		if (n_mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
